// ===== design/opaque_pixel_bounding_box_unit_macros.svh =====
// assertion macros for the opaque pixel bounding box unit
`ifndef OPAQUE_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH
`define OPAQUE_PIXEL_BOUNDING_BOX_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define OPBB_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("opbb check failed");

// condition holds in the cycle after the trigger
`define OPBB_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("opbb check failed");

`else

`define OPBB_ASSERT_NOW(lbl, clk, rst_n, trig, cond)
`define OPBB_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// ===== design/opbb_pkg.sv =====
// shared types and constants for the opaque pixel bounding box unit
`default_nettype none

package opbb_pkg;

    localparam int MAX_DIM = 4096;

    // format codes
    localparam logic [2:0] FMT_ARGB8888 = 3'd0;
    localparam logic [2:0] FMT_ARGB4444 = 3'd1;
    localparam logic [2:0] FMT_ARGB1555 = 3'd2;
    localparam logic [2:0] FMT_ALPHA8   = 3'd3;

    // register indexes
    localparam logic [2:0] CFG_FORMAT     = 3'd0;
    localparam logic [2:0] CFG_SURF_W     = 3'd1;
    localparam logic [2:0] CFG_SURF_H     = 3'd2;
    localparam logic [2:0] CFG_WIN_LEFT   = 3'd3;
    localparam logic [2:0] CFG_WIN_TOP    = 3'd4;
    localparam logic [2:0] CFG_WIN_RIGHT  = 3'd5;
    localparam logic [2:0] CFG_WIN_BOTTOM = 3'd6;

    localparam logic [7:0] NIBBLE_HI_MASK = 8'hf0;
    localparam logic [7:0] TOP_BIT_MASK   = 8'h80;

    // clamped search window, right and bottom exclusive
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } win_t;

endpackage

`default_nettype wire

// ===== design/opbb_pixel_test.sv =====
// window and alpha test for one pixel
`default_nettype none

module opbb_pixel_test
    import opbb_pkg::*;
(
    input  wire logic [2:0]  format_code,
    input  wire win_t        win,
    input  wire logic [11:0] pos_x,
    input  wire logic [11:0] pos_y,
    input  wire logic [31:0] pixel_bytes,
    output logic             hit
);

    logic signed [16:0] x_s;
    logic signed [16:0] y_s;
    logic               in_window;
    logic               opaque;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b3;

    assign x_s = $signed({5'b0, pos_x});
    assign y_s = $signed({5'b0, pos_y});
    assign b0  = pixel_bytes[7:0];
    assign b1  = pixel_bytes[15:8];
    assign b3  = pixel_bytes[31:24];

    assign in_window = (x_s >= $signed({win.left[15], win.left}))
                    && (x_s <  $signed({win.right[15], win.right}))
                    && (y_s >= $signed({win.top[15], win.top}))
                    && (y_s <  $signed({win.bottom[15], win.bottom}));

    always_comb
    begin
        unique case (format_code)
            FMT_ARGB8888: opaque = (b3 != 8'd0);
            FMT_ARGB4444: opaque = ((b1 & NIBBLE_HI_MASK) != 8'd0);
            FMT_ARGB1555: opaque = ((b1 & TOP_BIT_MASK) != 8'd0);
            FMT_ALPHA8:   opaque = (b0 != 8'd0);
            default:      opaque = 1'b1;
        endcase
    end

    assign hit = in_window && opaque;

endmodule

`default_nettype wire

// ===== design/opaque_pixel_bounding_box_unit.sv =====
// Opaque pixel bounding box: one pixel is taken per cycle while input ready is high. A pixel
// waits in the input register and is folded into the running box as it leaves; on the pixel
// marked last the box goes to the output register instead, and the result is offered from
// there. Input ready drops only while a last pixel waits behind a box that the downstream
// side has not yet taken. A write to any of register indexes 0 to 6 reloads the running box
// from the newly clamped window.
`default_nettype none

`include "opaque_pixel_bounding_box_unit_macros.svh"

module opaque_pixel_bounding_box_unit
    import opbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // pixel requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // pos_x[11:0], pos_y[23:12], pixel_bytes[55:24]
    input  wire logic        s_axis_tlast,  // last_pixel
    // box results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // box_min_x, box_min_y, box_max_x, box_max_y
    output logic             m_axis_tuser   // box_empty
);

    localparam logic signed [16:0] DimLimit = 17'(MAX_DIM);

    // configuration
    logic [2:0]         format_reg;
    logic [12:0]        surf_w_reg;
    logic [12:0]        surf_h_reg;
    logic signed [15:0] win_left_reg;
    logic signed [15:0] win_top_reg;
    logic signed [15:0] win_right_reg;
    logic signed [15:0] win_bottom_reg;
    logic               reload_reg;

    // input stage
    logic               p_valid_reg;
    logic [11:0]        p_x_reg;
    logic [11:0]        p_y_reg;
    logic [31:0]        p_px_reg;
    logic               p_last_reg;

    // running box
    logic signed [15:0] run_min_x_reg;
    logic signed [15:0] run_min_y_reg;
    logic signed [15:0] run_max_x_reg;
    logic signed [15:0] run_max_y_reg;

    // result stage
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_empty_reg;

    win_t               clamp;
    logic signed [16:0] surf_w_s;
    logic signed [16:0] surf_h_s;
    logic signed [16:0] right_s;
    logic signed [16:0] bottom_s;
    logic               hit;
    logic               advance;
    logic               s_accept;
    logic               cfg_hit;

    logic signed [15:0] base_min_x;
    logic signed [15:0] base_min_y;
    logic signed [15:0] base_max_x;
    logic signed [15:0] base_max_y;
    logic signed [15:0] px_x;
    logic signed [15:0] px_y;
    logic signed [15:0] min_x_next;
    logic signed [15:0] min_y_next;
    logic signed [15:0] max_x_next;
    logic signed [15:0] max_y_next;
    logic               empty_next;

    // window clamp
    always_comb
    begin
        surf_w_s = ($signed({4'b0, surf_w_reg}) > DimLimit) ? DimLimit
                                                          : $signed({4'b0, surf_w_reg});
        surf_h_s = ($signed({4'b0, surf_h_reg}) > DimLimit) ? DimLimit
                                                          : $signed({4'b0, surf_h_reg});
        right_s  = ($signed({win_right_reg[15], win_right_reg}) > surf_w_s)
                 ? surf_w_s : $signed({win_right_reg[15], win_right_reg});
        bottom_s = ($signed({win_bottom_reg[15], win_bottom_reg}) > surf_h_s)
                 ? surf_h_s : $signed({win_bottom_reg[15], win_bottom_reg});
        clamp.left   = win_left_reg[15] ? 16'sd0 : win_left_reg;
        clamp.top    = win_top_reg[15]  ? 16'sd0 : win_top_reg;
        clamp.right  = right_s[15:0];
        clamp.bottom = bottom_s[15:0];
    end

    opbb_pixel_test u_pixel_test (
        .format_code (format_reg),
        .win         (clamp),
        .pos_x       (p_x_reg),
        .pos_y       (p_y_reg),
        .pixel_bytes (p_px_reg),
        .hit         (hit)
    );

    assign advance  = p_valid_reg && (!p_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || advance;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_hit  = cfg_we && (cfg_index <= CFG_WIN_BOTTOM);

    // box update, starting from the clamped window if a write is still pending
    always_comb
    begin
        base_min_x = reload_reg ? clamp.right  : run_min_x_reg;
        base_min_y = reload_reg ? clamp.bottom : run_min_y_reg;
        base_max_x = reload_reg ? clamp.left   : run_max_x_reg;
        base_max_y = reload_reg ? clamp.top    : run_max_y_reg;
        px_x = $signed({4'b0, p_x_reg});
        px_y = $signed({4'b0, p_y_reg});
        min_x_next = (hit && px_x < base_min_x) ? px_x : base_min_x;
        min_y_next = (hit && px_y < base_min_y) ? px_y : base_min_y;
        max_x_next = (hit && px_x > base_max_x) ? px_x : base_max_x;
        max_y_next = (hit && px_y > base_max_y) ? px_y : base_max_y;
        empty_next = (min_x_next > max_x_next) || (min_y_next > max_y_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= FMT_ARGB8888;
            surf_w_reg     <= '0;
            surf_h_reg     <= '0;
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_right_reg  <= '0;
            win_bottom_reg <= '0;
            reload_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FORMAT:     format_reg     <= cfg_data[2:0];
                    CFG_SURF_W:     surf_w_reg     <= cfg_data[12:0];
                    CFG_SURF_H:     surf_h_reg     <= cfg_data[12:0];
                    CFG_WIN_LEFT:   win_left_reg   <= cfg_data;
                    CFG_WIN_TOP:    win_top_reg    <= cfg_data;
                    CFG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                    CFG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                    default:        ;
                endcase
            end
            // reload lands the cycle after the write, or folds into a pixel then
            reload_reg <= cfg_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_x_reg    <= s_axis_tdata[11:0];
            p_y_reg    <= s_axis_tdata[23:12];
            p_px_reg   <= s_axis_tdata[55:24];
            p_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_x_reg <= '0;
            run_min_y_reg <= '0;
            run_max_x_reg <= '0;
            run_max_y_reg <= '0;
        end
        else if (advance && !p_last_reg)
        begin
            run_min_x_reg <= min_x_next;
            run_min_y_reg <= min_y_next;
            run_max_x_reg <= max_x_next;
            run_max_y_reg <= max_y_next;
        end
        else if ((advance && p_last_reg) || reload_reg)
        begin
            run_min_x_reg <= clamp.right;
            run_min_y_reg <= clamp.bottom;
            run_max_x_reg <= clamp.left;
            run_max_y_reg <= clamp.top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && p_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p_last_reg)
        begin
            out_data_reg  <= {max_y_next, max_x_next, min_y_next, min_x_next};
            out_empty_reg <= empty_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_empty_reg;

    // a last pixel that leaves the input stage always yields a result next cycle
    `OPBB_ASSERT_NEXT(a_last_gives_box, clk, rst_n, advance && p_last_reg, m_axis_tvalid)

    // after a box is sent the running state restarts from the clamped window
    `OPBB_ASSERT_NEXT(a_reload_after_last, clk, rst_n, advance && p_last_reg && !cfg_we,
        run_min_x_reg == clamp.right && run_max_x_reg == clamp.left
        && run_min_y_reg == clamp.bottom && run_max_y_reg == clamp.top)

    // input is only held off behind a box that has not been taken
    `OPBB_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready && p_last_reg)

endmodule

`default_nettype wire

// ===== test/opbb_checker.sv =====
// checker for the opaque pixel bounding box unit: predicts boxes and compares results
`default_nettype none

module opbb_checker
    import opbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // pos_x[11:0], pos_y[23:12], pixel_bytes[55:24]
    input  wire logic        s_axis_tlast,  // last_pixel
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,  // box_min_x, box_min_y, box_max_x, box_max_y
    input  wire logic        m_axis_tuser,  // box_empty
    output int               fail_count,
    output int               boxes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic               empty;
    } box_t;

    box_t box_q[$];

    // register copies
    logic [2:0] fmt;
    int         surf_w;
    int         surf_h;
    int         req_l;
    int         req_t;
    int         req_r;
    int         req_b;

    // clamped window and running box
    int lim_l;
    int lim_t;
    int lim_r;
    int lim_b;
    int run_min_x;
    int run_min_y;
    int run_max_x;
    int run_max_y;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic reload_box();
        int w;
        int h;
        w = surf_w > MAX_DIM ? MAX_DIM : surf_w;
        h = surf_h > MAX_DIM ? MAX_DIM : surf_h;
        lim_l = req_l < 0 ? 0 : req_l;
        lim_t = req_t < 0 ? 0 : req_t;
        lim_r = req_r > w ? w : req_r;
        lim_b = req_b > h ? h : req_b;
        run_min_x = lim_r;
        run_min_y = lim_b;
        run_max_x = lim_l;
        run_max_y = lim_t;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int          px;
        int          py;
        logic [31:0] bytes;
        logic        opaque;
        box_t        want;
        box_t        got;
        if (!rst_n)
        begin
            fmt = FMT_ARGB8888;
            surf_w = 0;
            surf_h = 0;
            req_l = 0;
            req_t = 0;
            req_r = 0;
            req_b = 0;
            reload_box();
            box_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.min_x = m_axis_tdata[15:0];
                got.min_y = m_axis_tdata[31:16];
                got.max_x = m_axis_tdata[47:32];
                got.max_y = m_axis_tdata[63:48];
                got.empty = m_axis_tuser;
                if (box_q.size() == 0)
                    report_mismatch("box result with no box expected");
                else
                begin
                    want = box_q.pop_front();
                    if (got.min_x !== want.min_x)
                        report_mismatch($sformatf("box_min_x got %0d want %0d",
                                                  got.min_x, want.min_x));
                    if (got.min_y !== want.min_y)
                        report_mismatch($sformatf("box_min_y got %0d want %0d",
                                                  got.min_y, want.min_y));
                    if (got.max_x !== want.max_x)
                        report_mismatch($sformatf("box_max_x got %0d want %0d",
                                                  got.max_x, want.max_x));
                    if (got.max_y !== want.max_y)
                        report_mismatch($sformatf("box_max_y got %0d want %0d",
                                                  got.max_y, want.max_y));
                    if (got.empty !== want.empty)
                        report_mismatch($sformatf("box_empty got %0b want %0b",
                                                  got.empty, want.empty));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                px = s_axis_tdata[11:0];
                py = s_axis_tdata[23:12];
                bytes = s_axis_tdata[55:24];
                case (fmt)
                    FMT_ARGB8888: opaque = bytes[31:24] != 8'd0;
                    FMT_ARGB4444: opaque = (bytes[15:8] & NIBBLE_HI_MASK) != 8'd0;
                    FMT_ARGB1555: opaque = (bytes[15:8] & TOP_BIT_MASK) != 8'd0;
                    FMT_ALPHA8:   opaque = bytes[7:0] != 8'd0;
                    default:      opaque = 1'b1;
                endcase
                if (opaque && px >= lim_l && px < lim_r && py >= lim_t && py < lim_b)
                begin
                    if (px < run_min_x) run_min_x = px;
                    if (py < run_min_y) run_min_y = py;
                    if (px > run_max_x) run_max_x = px;
                    if (py > run_max_y) run_max_y = py;
                end
                if (s_axis_tlast)
                begin
                    want.min_x = 16'(run_min_x);
                    want.min_y = 16'(run_min_y);
                    want.max_x = 16'(run_max_x);
                    want.max_y = 16'(run_max_y);
                    want.empty = run_min_x > run_max_x || run_min_y > run_max_y;
                    box_q.push_back(want);
                    reload_box();
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FORMAT:     fmt = cfg_data[2:0];
                    CFG_SURF_W:     surf_w = cfg_data[12:0];
                    CFG_SURF_H:     surf_h = cfg_data[12:0];
                    CFG_WIN_LEFT:   req_l = $signed(cfg_data);
                    CFG_WIN_TOP:    req_t = $signed(cfg_data);
                    CFG_WIN_RIGHT:  req_r = $signed(cfg_data);
                    CFG_WIN_BOTTOM: req_b = $signed(cfg_data);
                    default: ;
                endcase
                // an unused index leaves the running box alone
                if (cfg_index <= CFG_WIN_BOTTOM)
                    reload_box();
            end
        end
        boxes_due = box_q.size();
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// top of the opaque pixel bounding box testbench: clock, reset, stimulus and verdict
`default_nettype none

module tb_top;
    import opbb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic [2:0] FMT_ALWAYS = 3'd4;
    localparam logic [2:0] FMT_TOP    = 3'd7;   // highest spare format code
    localparam int RANDOM_ITEMS   = 1930;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // pos_x[11:0], pos_y[23:12], pixel_bytes[55:24]
    logic        s_axis_tlast = 1'b0;  // last_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;  // box_min_x, box_min_y, box_max_x, box_max_y
    logic        m_axis_tuser;  // box_empty

    int fail_count;
    int boxes_due;
    int idle_cycles = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 78;

    // stimulus-side copy of the surface and window, only to aim pixels
    int sh_w;
    int sh_h;
    int sh_l;
    int sh_t;
    int sh_r;
    int sh_b;

    opaque_pixel_bounding_box_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    opbb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .boxes_due     (boxes_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= $urandom_range(99) >= rx_idle_pct;

    // nothing accepted on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL opaque_pixel_bounding_box_unit");
            $finish;
        end
    end

    task automatic send_pixel(input int x, input int y, input logic [31:0] bytes,
                              input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {bytes, 12'(y), 12'(x)};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold requests until every box is out and the pipeline has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (boxes_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_config(input int f, input int w, input int h, input int l,
                                input int t, input int r, input int b);
        settle();
        write_reg(CFG_FORMAT, f);
        write_reg(CFG_SURF_W, w);
        write_reg(CFG_SURF_H, h);
        write_reg(CFG_WIN_LEFT, l);
        write_reg(CFG_WIN_TOP, t);
        write_reg(CFG_WIN_RIGHT, r);
        write_reg(CFG_WIN_BOTTOM, b);
        sh_w = w % 8192;
        sh_h = h % 8192;
        sh_l = l;
        sh_t = t;
        sh_r = r;
        sh_b = b;
    endtask

    function automatic int pick_edge(input int span, input bit far_side);
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return int'($urandom_range(65535)) - 32768;
            default:
                if (far_side)
                    return span / 2 + int'($urandom_range(span / 2 + 3));
                else
                    return int'($urandom_range(span / 2 + 1)) - 2;
        endcase
    endfunction

    // mostly near the window so that the box moves, sometimes anywhere
    function automatic int pick_coord(input int lo, input int hi);
        int a;
        int b;
        if (hi <= lo || $urandom_range(7) == 0)
            return $urandom_range(4095);
        a = lo > 2 ? lo - 2 : 0;
        b = hi < 4095 ? hi + 1 : 4095;
        return $urandom_range(b, a);
    endfunction

    task automatic random_config();
        int f;
        int w;
        int h;
        f = $urandom_range(7);
        case ($urandom_range(5))
            0: w = $urandom_range(8191);
            1: w = MAX_DIM;
            default: w = $urandom_range(64, 1);
        endcase
        case ($urandom_range(5))
            0: h = $urandom_range(8191);
            1: h = MAX_DIM;
            default: h = $urandom_range(64, 1);
        endcase
        // junk above the register width now and then
        if ($urandom_range(3) == 0)
        begin
            f += 8 * int'($urandom_range(8191));
            w += 8192 * int'($urandom_range(7));
            h += 8192 * int'($urandom_range(7));
        end
        apply_config(f, w, h, pick_edge(w % 8192, 1'b0), pick_edge(h % 8192, 1'b0),
                     pick_edge(w % 8192, 1'b1), pick_edge(h % 8192, 1'b1));
    endtask

    task automatic random_phase(input int items);
        int          sent;
        int          scans;
        int          len;
        int          lo_x;
        int          hi_x;
        int          lo_y;
        int          hi_y;
        logic [31:0] bytes;
        sent = 0;
        while (sent < items)
        begin
            random_config();
            lo_x = sh_l < 0 ? 0 : sh_l;
            lo_y = sh_t < 0 ? 0 : sh_t;
            hi_x = sh_w > MAX_DIM ? MAX_DIM : sh_w;
            hi_y = sh_h > MAX_DIM ? MAX_DIM : sh_h;
            hi_x = sh_r < hi_x ? sh_r : hi_x;
            hi_y = sh_b < hi_y ? sh_b : hi_y;
            scans = $urandom_range(10, 3);
            for (int s = 0; s < scans && sent < items; s++)
            begin
                len = $urandom_range(7) == 0 ? $urandom_range(60, 1) : $urandom_range(20, 1);
                for (int i = 0; i < len; i++)
                begin
                    bytes = $urandom;
                    case ($urandom_range(5))
                        0: bytes[31:24] = 8'd0;
                        1: bytes[15:12] = 4'd0;
                        2: bytes[15] = 1'b0;
                        3: bytes[7:0] = 8'd0;
                        4: bytes = 32'd0;
                        default: ;
                    endcase
                    send_pixel(pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y), bytes,
                               i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window is zero wide yet min equals max
        send_pixel(0, 0, 32'hffffffff, 1'b1);

        // full window; a register write mid-scan drops the first pixel
        apply_config(FMT_ARGB8888, MAX_DIM, MAX_DIM, -32768, -32768, 32767, 32767);
        send_pixel(4095, 0, 32'hff000000, 1'b0);
        settle();
        write_reg(CFG_FORMAT, FMT_ARGB8888);
        send_pixel(0, 0, 32'h00ffffff, 1'b0);
        send_pixel(0, 4095, 32'h01000000, 1'b0);
        send_pixel(4095, 4095, 32'h80000000, 1'b1);

        // oversized surface; unused index write keeps the box; last pixel outside
        apply_config(FMT_ARGB4444, 8191, 5000, 10, 20, 100, 200);
        send_pixel(9, 20, 32'hffffffff, 1'b0);
        send_pixel(10, 20, 32'h00001000, 1'b0);
        settle();
        write_reg(CFG_UNUSED, 16'hffff);
        send_pixel(99, 199, 32'h00000f00, 1'b0);
        send_pixel(99, 199, 32'h0000f000, 1'b0);
        send_pixel(100, 50, 32'hffffffff, 1'b1);

        apply_config(FMT_ARGB1555, 8191, 5000, 10, 20, 100, 200);
        send_pixel(50, 50, 32'h00007fff, 1'b0);
        send_pixel(60, 70, 32'h00008000, 1'b1);

        // empty box, then a single opaque pixel
        apply_config(FMT_ALPHA8, 8191, 5000, 10, 20, 100, 200);
        send_pixel(50, 50, 32'hffffff00, 1'b1);
        send_pixel(55, 56, 32'h00000001, 1'b1);

        // codes past alpha8 treat every pixel as opaque
        for (int f = FMT_ALWAYS; f <= FMT_TOP; f++)
        begin
            apply_config(f, MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM);
            send_pixel(7, 9, 32'h00000000, 1'b1);
        end

        // zero surface with a negative right edge
        apply_config(FMT_ARGB8888, 0, 0, -1, -1, -5, 32767);
        send_pixel(0, 0, 32'hffffffff, 1'b1);

        random_phase(RANDOM_ITEMS / 3);
        tx_idle_pct = 78;
        rx_idle_pct = 18;
        random_phase(RANDOM_ITEMS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(RANDOM_ITEMS / 3);

        settle();
        if (fail_count == 0)
            $display("PASS opaque_pixel_bounding_box_unit");
        else
            $display("FAIL opaque_pixel_bounding_box_unit");
        $finish;
    end

endmodule

`default_nettype wire
